FILE: src/indexed_min_heap_unit_macros.svh
// Assertion macros used by the heap unit checker.
`ifndef INDEXED_MIN_HEAP_UNIT_MACROS_SVH
`define INDEXED_MIN_HEAP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IMH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap unit check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define IMH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heap unit check failed");

`endif

FILE: src/imh_pkg.sv
// Shared types, constants and command codes of the indexed min-heap unit.
package imh_pkg;

  localparam int CAPACITY = 1024;
  localparam int ID_COUNT = 1024;
  localparam int KEY_BITS = 32;
  localparam int ID_W     = $clog2(ID_COUNT);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int SLOT_W   = $clog2(CAPACITY + 1);

  typedef logic [ID_W-1:0]     id_t;
  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [1:0]          req_t;
  typedef logic [1:0]          st_t;
  typedef logic [3:0]          op_t;

  typedef struct packed {
    id_t  id;
    key_t key;
  } heap_ent_t;

  // request codes
  localparam req_t REQ_PUSH = 2'd0;
  localparam req_t REQ_POP  = 2'd1;
  localparam req_t REQ_UPD  = 2'd2;

  // status codes
  localparam st_t ST_OK       = 2'd0;
  localparam st_t ST_FULL     = 2'd1;
  localparam st_t ST_EMPTY    = 2'd2;
  localparam st_t ST_CONFLICT = 2'd3;

  // datapath operations
  localparam op_t OP_NONE      = 4'd0;
  localparam op_t OP_CLEAR     = 4'd1;
  localparam op_t OP_ACCEPT    = 4'd2;
  localparam op_t OP_PUSH_INIT = 4'd3;
  localparam op_t OP_UPD_INIT  = 4'd4;
  localparam op_t OP_POP_RD1   = 4'd5;
  localparam op_t OP_POP_TOP   = 4'd6;
  localparam op_t OP_POP_LAST  = 4'd7;
  localparam op_t OP_UP_RD     = 4'd8;
  localparam op_t OP_UP_MOVE   = 4'd9;
  localparam op_t OP_DN_RDL    = 4'd10;
  localparam op_t OP_DN_LATL   = 4'd11;
  localparam op_t OP_DN_LATR   = 4'd12;
  localparam op_t OP_DN_MOVE   = 4'd13;
  localparam op_t OP_PLACE     = 4'd14;
  localparam op_t OP_TOP_LAT   = 4'd15;

  typedef struct packed {
    op_t op;
    logic top_rd;
    logic st_we;
    st_t  st;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic present;
    logic cnt_zero;
    logic cnt_one;
    logic cnt_full;
    logic at_root;
    logic up_swap;
    logic has_child;
    logic has_right;
    logic dn_swap;
    logic moved;
    logic popped;
    req_t req;
  } dp_stat_t;

endpackage

FILE: src/imh_if.sv
// Valid/ready channel interfaces for heap requests and results.
interface imh_req_if;
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  imh_pkg::id_t     item_id;
  imh_pkg::key_t    item_key;
  modport source (output valid, output req_type, output item_id, output item_key,
                  input ready);
  modport sink   (input valid, input req_type, input item_id, input item_key,
                  output ready);
endinterface

interface imh_rsp_if;
  logic             valid;
  logic             ready;
  imh_pkg::id_t     top_id;
  imh_pkg::key_t    top_key;
  logic             top_valid;
  imh_pkg::slot_t   entry_count;
  imh_pkg::st_t     status;
  modport source (output valid, output top_id, output top_key, output top_valid,
                  output entry_count, output status, input ready);
  modport sink   (input valid, input top_id, input top_key, input top_valid,
                  input entry_count, input status, output ready);
endinterface

FILE: src/imh_ctrl.sv
// Controller state machine: sequences clearing, sifts and result hand-off.
module imh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  imh_pkg::dp_stat_t  stat,
  output imh_pkg::dp_cmd_t   cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_UP    = 4'd3;
  localparam logic [3:0] S_UPC   = 4'd4;
  localparam logic [3:0] S_POP1  = 4'd5;
  localparam logic [3:0] S_POP2  = 4'd6;
  localparam logic [3:0] S_DN    = 4'd7;
  localparam logic [3:0] S_DNL   = 4'd8;
  localparam logic [3:0] S_DNR   = 4'd9;
  localparam logic [3:0] S_DNC   = 4'd10;
  localparam logic [3:0] S_TOP   = 4'd11;
  localparam logic [3:0] S_TOPL  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       down_after_up;

  // an update that did not rise goes on to sift down
  assign down_after_up = (stat.req == imh_pkg::REQ_UPD) && !stat.moved;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = imh_pkg::OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.op = imh_pkg::OP_CLEAR;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = imh_pkg::OP_ACCEPT;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = S_TOP;
        case (stat.req)
          imh_pkg::REQ_PUSH: begin
            if (stat.present) begin
              cmd.st_we = 1'b1;
              cmd.st    = imh_pkg::ST_CONFLICT;
            end else if (stat.cnt_full) begin
              cmd.st_we = 1'b1;
              cmd.st    = imh_pkg::ST_FULL;
            end else begin
              cmd.op    = imh_pkg::OP_PUSH_INIT;
              state_nxt = S_UP;
            end
          end
          imh_pkg::REQ_POP: begin
            if (stat.cnt_zero) begin
              cmd.st_we = 1'b1;
              cmd.st    = imh_pkg::ST_EMPTY;
            end else begin
              cmd.op    = imh_pkg::OP_POP_RD1;
              state_nxt = S_POP1;
            end
          end
          imh_pkg::REQ_UPD: begin
            if (!stat.present) begin
              cmd.st_we = 1'b1;
              cmd.st    = imh_pkg::ST_CONFLICT;
            end else begin
              cmd.op    = imh_pkg::OP_UPD_INIT;
              state_nxt = S_UP;
            end
          end
          default: state_nxt = S_TOP;
        endcase
      end
      S_UP: begin
        if (!stat.at_root) begin
          cmd.op    = imh_pkg::OP_UP_RD;
          state_nxt = S_UPC;
        end else if (down_after_up) begin
          state_nxt = S_DN;
        end else begin
          cmd.op    = imh_pkg::OP_PLACE;
          state_nxt = S_TOP;
        end
      end
      S_UPC: begin
        if (stat.up_swap) begin
          cmd.op    = imh_pkg::OP_UP_MOVE;
          state_nxt = S_UP;
        end else if (down_after_up) begin
          state_nxt = S_DN;
        end else begin
          cmd.op    = imh_pkg::OP_PLACE;
          state_nxt = S_TOP;
        end
      end
      S_POP1: begin
        cmd.op    = imh_pkg::OP_POP_TOP;
        state_nxt = S_POP2;
      end
      S_POP2: begin
        cmd.op    = imh_pkg::OP_POP_LAST;
        state_nxt = stat.cnt_one ? S_OUT : S_DN;
      end
      S_DN: begin
        if (stat.has_child) begin
          cmd.op    = imh_pkg::OP_DN_RDL;
          state_nxt = S_DNL;
        end else begin
          cmd.op    = imh_pkg::OP_PLACE;
          state_nxt = S_TOP;
        end
      end
      S_DNL: begin
        cmd.op    = imh_pkg::OP_DN_LATL;
        state_nxt = stat.has_right ? S_DNR : S_DNC;
      end
      S_DNR: begin
        cmd.op    = imh_pkg::OP_DN_LATR;
        state_nxt = S_DNC;
      end
      S_DNC: begin
        if (stat.dn_swap) begin
          cmd.op    = imh_pkg::OP_DN_MOVE;
          state_nxt = S_DN;
        end else begin
          cmd.op    = imh_pkg::OP_PLACE;
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        if (stat.popped || stat.cnt_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.top_rd = 1'b1;
          state_nxt  = S_TOPL;
        end
      end
      S_TOPL: begin
        cmd.op    = imh_pkg::OP_TOP_LAT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // result beat valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: src/imh_dp.sv
// Datapath: heap and position memories, sift registers and result register.
module imh_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_req_type,
  input  imh_pkg::id_t      in_item_id,
  input  imh_pkg::key_t     in_item_key,
  input  imh_pkg::dp_cmd_t  cmd,
  output imh_pkg::dp_stat_t stat,
  output imh_pkg::id_t      out_top_id,
  output imh_pkg::key_t     out_top_key,
  output logic              out_top_valid,
  output imh_pkg::slot_t    out_entry_count,
  output imh_pkg::st_t      out_status
);

  localparam imh_pkg::slot_t ROOT = imh_pkg::SLOT_W'(1);

  // memories
  imh_pkg::heap_ent_t heap_mem [imh_pkg::CAPACITY];
  imh_pkg::slot_t     pos_mem  [imh_pkg::ID_COUNT];

  imh_pkg::heap_ent_t heap_rd_r;
  imh_pkg::slot_t     pos_rd_r;

  // request and sift registers
  imh_pkg::req_t   req_r;
  imh_pkg::id_t    id_r;
  imh_pkg::key_t   key_r;
  imh_pkg::slot_t  cnt_r, cnt_nxt;
  imh_pkg::slot_t  s_r, s_nxt;
  imh_pkg::heap_ent_t cur_r, cur_nxt;
  imh_pkg::heap_ent_t best_r, best_nxt;
  imh_pkg::slot_t  best_slot_r, best_slot_nxt;
  logic            moved_r, moved_nxt;
  logic            popped_r, popped_nxt;
  imh_pkg::heap_ent_t res_r, res_nxt;
  logic            res_valid_r, res_valid_nxt;
  imh_pkg::st_t    st_r, st_nxt;
  imh_pkg::id_t    clr_r;

  // write and read port controls
  logic               heap_we, heap_re, pos_we;
  imh_pkg::slot_t     heap_wslot, heap_rslot;
  imh_pkg::heap_ent_t heap_wdata;
  imh_pkg::id_t       pos_waddr;
  imh_pkg::slot_t     pos_wdata;

  logic [imh_pkg::SLOT_W:0] left_ext, right_ext, cnt_ext;
  imh_pkg::slot_t           left_slot, right_slot;

  function automatic imh_pkg::addr_t slot_addr(input imh_pkg::slot_t s);
    imh_pkg::slot_t m;
    m = s - imh_pkg::SLOT_W'(1);
    return m[imh_pkg::ADDR_W-1:0];
  endfunction

  assign left_ext   = {s_r, 1'b0};
  assign right_ext  = {s_r, 1'b1};
  assign cnt_ext    = {1'b0, cnt_r};
  assign left_slot  = left_ext[imh_pkg::SLOT_W-1:0];
  assign right_slot = right_ext[imh_pkg::SLOT_W-1:0];

  // status to the controller
  always_comb begin
    stat.clr_done  = (clr_r == imh_pkg::ID_W'(imh_pkg::ID_COUNT - 1));
    stat.present   = (pos_rd_r != '0);
    stat.cnt_zero  = (cnt_r == '0);
    stat.cnt_one   = (cnt_r == ROOT);
    stat.cnt_full  = (cnt_r == imh_pkg::SLOT_W'(imh_pkg::CAPACITY));
    stat.at_root   = (s_r == ROOT);
    stat.up_swap   = (heap_rd_r.key > cur_r.key);
    stat.has_child = (left_ext <= cnt_ext);
    stat.has_right = (right_ext <= cnt_ext);
    stat.dn_swap   = (cur_r.key > best_r.key);
    stat.moved     = moved_r;
    stat.popped    = popped_r;
    stat.req       = req_r;
  end

  // datapath operations
  always_comb begin
    cnt_nxt       = cnt_r;
    s_nxt         = s_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    best_slot_nxt = best_slot_r;
    moved_nxt     = moved_r;
    popped_nxt    = popped_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r;
    st_nxt        = cmd.st_we ? cmd.st : st_r;
    heap_we       = 1'b0;
    heap_wslot    = s_r;
    heap_wdata    = cur_r;
    heap_re       = cmd.top_rd;
    heap_rslot    = ROOT;
    pos_we        = 1'b0;
    pos_waddr     = cur_r.id;
    pos_wdata     = s_r;
    case (cmd.op)
      imh_pkg::OP_CLEAR: begin
        pos_we    = 1'b1;
        pos_waddr = clr_r;
        pos_wdata = '0;
      end
      imh_pkg::OP_ACCEPT: begin
        st_nxt        = imh_pkg::ST_OK;
        res_nxt       = '0;
        res_valid_nxt = 1'b0;
        popped_nxt    = 1'b0;
        moved_nxt     = 1'b0;
      end
      imh_pkg::OP_PUSH_INIT: begin
        cnt_nxt = cnt_r + imh_pkg::SLOT_W'(1);
        s_nxt   = cnt_r + imh_pkg::SLOT_W'(1);
        cur_nxt = '{id: id_r, key: key_r};
      end
      imh_pkg::OP_UPD_INIT: begin
        s_nxt   = pos_rd_r;
        cur_nxt = '{id: id_r, key: key_r};
      end
      imh_pkg::OP_POP_RD1: begin
        heap_re    = 1'b1;
        heap_rslot = ROOT;
      end
      imh_pkg::OP_POP_TOP: begin
        res_nxt       = heap_rd_r;
        res_valid_nxt = 1'b1;
        popped_nxt    = 1'b1;
        heap_re       = 1'b1;
        heap_rslot    = cnt_r;
      end
      imh_pkg::OP_POP_LAST: begin
        pos_we    = 1'b1;
        pos_waddr = res_r.id;
        pos_wdata = '0;
        cur_nxt   = heap_rd_r;
        cnt_nxt   = cnt_r - imh_pkg::SLOT_W'(1);
        s_nxt     = ROOT;
      end
      imh_pkg::OP_UP_RD: begin
        heap_re    = 1'b1;
        heap_rslot = s_r >> 1;
      end
      imh_pkg::OP_UP_MOVE: begin
        heap_we    = 1'b1;
        heap_wdata = heap_rd_r;
        pos_we     = 1'b1;
        pos_waddr  = heap_rd_r.id;
        s_nxt      = s_r >> 1;
        moved_nxt  = 1'b1;
      end
      imh_pkg::OP_DN_RDL: begin
        heap_re    = 1'b1;
        heap_rslot = left_slot;
      end
      imh_pkg::OP_DN_LATL: begin
        best_nxt      = heap_rd_r;
        best_slot_nxt = left_slot;
        heap_re       = 1'b1;
        heap_rslot    = right_slot;
      end
      imh_pkg::OP_DN_LATR: begin
        // right child wins only when strictly smaller
        if (best_r.key > heap_rd_r.key) begin
          best_nxt      = heap_rd_r;
          best_slot_nxt = right_slot;
        end
      end
      imh_pkg::OP_DN_MOVE: begin
        heap_we    = 1'b1;
        heap_wdata = best_r;
        pos_we     = 1'b1;
        pos_waddr  = best_r.id;
        s_nxt      = best_slot_r;
      end
      imh_pkg::OP_PLACE: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      imh_pkg::OP_TOP_LAT: begin
        res_nxt       = heap_rd_r;
        res_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[slot_addr(heap_wslot)] <= heap_wdata;
    if (heap_re) heap_rd_r <= heap_mem[slot_addr(heap_rslot)];
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    if (cmd.op == imh_pkg::OP_ACCEPT) pos_rd_r <= pos_mem[in_item_id];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      clr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.op == imh_pkg::OP_CLEAR) clr_r <= clr_r + imh_pkg::ID_W'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == imh_pkg::OP_ACCEPT) begin
      req_r <= in_req_type;
      id_r  <= in_item_id;
      key_r <= in_item_key;
    end
    s_r         <= s_nxt;
    cur_r       <= cur_nxt;
    best_r      <= best_nxt;
    best_slot_r <= best_slot_nxt;
    moved_r     <= moved_nxt;
    popped_r    <= popped_nxt;
    res_r       <= res_nxt;
    res_valid_r <= res_valid_nxt;
    st_r        <= st_nxt;
    if (cmd.out_load) begin
      out_top_id      <= res_r.id;
      out_top_key     <= res_r.key;
      out_top_valid   <= res_valid_r;
      out_entry_count <= cnt_r;
      out_status      <= st_r;
    end
  end

endmodule

FILE: src/indexed_min_heap_unit.sv
// Top level of the indexed min-heap unit: controller plus datapath.
//
//   channel  | dir | interface  | beat
//   in_ch    | in  | imh_req_if | one request (push, pop, update key)
//   out_ch   | out | imh_rsp_if | one result per request
//
// After reset a clearing pass writes the 1024-entry position map, one entry a
// cycle, with in_ch.ready low. The single read port of the heap memory sets
// the pace of the sift up and the sift down of a request.
// One request is in work at a time; a finished result waits in the output
// register while the next request is accepted.
module indexed_min_heap_unit (
  input logic       clk,
  input logic       rst_n,
  imh_req_if.sink   in_ch,
  imh_rsp_if.source out_ch
);

  imh_pkg::dp_cmd_t  cmd;
  imh_pkg::dp_stat_t stat;

  imh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  imh_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_req_type     (in_ch.req_type),
    .in_item_id      (in_ch.item_id),
    .in_item_key     (in_ch.item_key),
    .cmd             (cmd),
    .stat            (stat),
    .out_top_id      (out_ch.top_id),
    .out_top_key     (out_ch.top_key),
    .out_top_valid   (out_ch.top_valid),
    .out_entry_count (out_ch.entry_count),
    .out_status      (out_ch.status)
  );

endmodule

FILE: src/imh_checker.sv
// Port-level checker for the indexed min-heap unit, bound to the top level.
`include "indexed_min_heap_unit_macros.svh"

module imh_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input imh_pkg::id_t   top_id,
  input imh_pkg::key_t  top_key,
  input logic           top_valid,
  input imh_pkg::slot_t entry_count,
  input imh_pkg::st_t   status
);

  // stalled result beat holds
  `IMH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(top_id) && $stable(top_key) && $stable(entry_count) && $stable(status))

  // no entry reported means zero fields
  `IMH_ASSERT_NOW(a_empty_zero, out_valid && !top_valid, top_id == '0 && top_key == '0)

  // count never exceeds capacity
  `IMH_ASSERT_NOW(a_cnt_range, out_valid, entry_count <= imh_pkg::SLOT_W'(imh_pkg::CAPACITY))

  // empty status only on an empty heap with no entry
  `IMH_ASSERT_NOW(a_empty_st, out_valid && status == imh_pkg::ST_EMPTY, !top_valid && entry_count == '0)

  // a non-empty heap always reports a top
  `IMH_ASSERT_NOW(a_top_present, out_valid && entry_count != '0, top_valid)

endmodule

bind indexed_min_heap_unit imh_checker u_imh_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .top_id      (out_ch.top_id),
  .top_key     (out_ch.top_key),
  .top_valid   (out_ch.top_valid),
  .entry_count (out_ch.entry_count),
  .status      (out_ch.status)
);
